// ===== hw/rtl/parallel_port_audio_dac_fifo_defines.svh =====
// Assertion macros for the main RTL file of the parallel-port DAC.
`ifndef PARALLEL_PORT_AUDIO_DAC_FIFO_DEFINES_SVH
`define PARALLEL_PORT_AUDIO_DAC_FIFO_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPAD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ppad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ppad_pkg;

  // Sample FIFO geometry.
  localparam int FIFO_DEPTH = 256;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);
  localparam int THR_W      = 9;
  localparam int CMP_W      = (OCC_W > THR_W) ? OCC_W : THR_W;

  // Reset values of the registers and the limit on the volume shift.
  localparam logic [3:0]       VOL_RESET = 4'd7;
  localparam logic [THR_W-1:0] THR_RESET = 9'd16;
  localparam logic [3:0]       VOL_MAX   = 4'd8;
  localparam logic [7:0]       LATCH_MID = 8'd128;

  // Device modes.
  typedef enum logic [1:0] {
    MODE_SILENT = 2'd0,
    MODE_DIRECT = 2'd1,
    MODE_FIFO   = 2'd2,
    MODE_STEREO = 2'd3
  } mode_t;

  // Event codes carried in the input tuser.
  localparam logic [1:0] OP_STROBE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_SELECT = 2'd2;

  // Register indexes.
  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_VOLUME    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  // Where the second stage takes its sample pair from.
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_PAIR,
    SRC_POP,
    SRC_ZERO,
    SRC_HOLD
  } src_t;

  // Event decoded in the first stage, finished in the second.
  typedef struct packed {
    logic       smp_valid;
    src_t       src;
    logic [7:0] byte_l;
    logic [7:0] byte_r;
    logic       full;
    logic       ovf;
  } stage_t;

  // Centre the byte and scale it by the volume, clamped at eight places.
  function automatic logic [15:0] to_sample(input logic [7:0] b, input logic [3:0] vol);
    logic [3:0]  sh;
    logic [15:0] c;
    sh = (vol > VOL_MAX) ? VOL_MAX : vol;
    c  = {{8{~b[7]}}, ~b[7], b[6:0]};
    return c << sh;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/parallel_port_audio_dac_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "parallel_port_audio_dac_fifo_defines.svh"
// Parallel-port sound device: direct byte DAC, FIFO sound source or stereo latch.
// Input channel: one port event per item; in_tuser holds the event code
// (strobe, tick, select change), in_tdata the data lines and the select level.
// Output channel: exactly one result item per input item, in order; out_tuser
// is high when the item carries a sample pair.
// Configuration channel: cfg_index picks mode, volume shift or full threshold;
// cfg_ready is always high. Writing the mode clears pointers, occupancy, flags,
// held sample and stereo latches. Writes are to be made while no item is in
// flight; the block does not enforce this. Throughput is one item per cycle
// while out_tready is high; an item passes the first-stage and output registers.
// The first stage updates the control state and issues the read of the sample
// memory, whose registered read port feeds the second stage, where the popped
// byte is scaled and the held sample updated.
// When out_tready is low the result waits in the output register, the first
// stage still takes one further item, and in_tready then drops until the
// output moves on. Reset (rst_n low, synchronous) empties both stages and
// restores direct mode, volume shift 7 and threshold 16. The sample memory
// is not cleared; only entries written since the last clear are ever read.
module parallel_port_audio_dac_fifo (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  // Input events.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] data_byte, [8] select_level, rest zero
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  // Results.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [15:0] left_sample, [31:16] right_sample,
                                       // [32] fifo_full, [33] overflow, rest zero
  output logic             out_tuser   // [0] sample_valid
);
  import ppad_pkg::*;

  // Configuration registers.
  mode_t            mode_r;
  logic [3:0]       vol_r;
  logic [THR_W-1:0] thr_r;

  // Control state.
  logic [PTR_W-1:0] rd_ptr_r,  rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r,  wr_ptr_nxt;
  logic [OCC_W-1:0] occ_r,     occ_nxt;
  logic             full_r,    full_nxt;
  logic             parity_r,  parity_nxt;
  logic [7:0]       left_r,    left_nxt;
  logic [7:0]       right_r,   right_nxt;
  logic             seen_r,    seen_nxt;
  logic [15:0]      held_r,    held_nxt;

  // Pipeline.
  logic             s1_valid_r;
  stage_t           s1_r,      s1_nxt;
  logic             out_valid_r;
  logic [39:0]      out_data_r;
  logic             out_user_r;

  // Sample memory.
  logic [7:0]       mem [FIFO_DEPTH];
  logic [7:0]       rdata_r;
  logic             wr_en;
  logic             rd_en;

  logic             accept;
  logic             advance;
  logic             cfg_wr;
  logic [1:0]       op;
  logic [7:0]       in_byte;
  logic             in_level;
  logic [15:0]      smp_l;
  logic [15:0]      smp_r;
  logic [CMP_W-1:0] occ_inc;
  logic [CMP_W-1:0] occ_dec;
  logic [CMP_W-1:0] thr_ext;

  assign op       = in_tuser;
  assign in_byte  = in_tdata[7:0];
  assign in_level = in_tdata[8];

  // Handshakes: the output register frees the first stage, which frees the input.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign occ_inc = CMP_W'(occ_r) + CMP_W'(1);
  assign occ_dec = CMP_W'(occ_r) - CMP_W'(1);
  assign thr_ext = CMP_W'(thr_r);

  // First stage: decode the event against the mode and update control state.
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    occ_nxt    = occ_r;
    full_nxt   = full_r;
    parity_nxt = parity_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    seen_nxt   = seen_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    s1_nxt     = '{smp_valid: 1'b0, src: SRC_NONE, byte_l: in_byte, byte_r: in_byte,
                   full: full_r, ovf: 1'b0};
    case (mode_r)
      MODE_DIRECT: begin
        if (op == OP_TICK) begin
          s1_nxt.smp_valid = 1'b1;
          s1_nxt.src       = SRC_PAIR;
        end
      end
      MODE_FIFO: begin
        if (op == OP_STROBE) begin
          if (occ_r == OCC_W'(FIFO_DEPTH)) begin
            s1_nxt.ovf = 1'b1;
          end else begin
            wr_en      = 1'b1;
            wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
            occ_nxt    = occ_r + OCC_W'(1);
            if (occ_inc >= thr_ext) begin
              full_nxt = 1'b1;
            end
          end
        end else if (op == OP_TICK) begin
          s1_nxt.smp_valid = 1'b1;
          s1_nxt.src       = SRC_HOLD;
          if (parity_r) begin
            if (occ_r != '0) begin
              rd_en      = 1'b1;
              rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
              occ_nxt    = occ_r - OCC_W'(1);
              s1_nxt.src = SRC_POP;
              if (occ_dec < thr_ext) begin
                full_nxt = 1'b0;
              end
            end else begin
              s1_nxt.src = SRC_ZERO;
              if (CMP_W'(occ_r) < thr_ext) begin
                full_nxt = 1'b0;
              end
            end
          end
          parity_nxt = !parity_r;
        end
      end
      MODE_STEREO: begin
        if (op == OP_SELECT) begin
          if (in_level && !seen_r) begin
            left_nxt = in_byte;
          end else if (!in_level && seen_r) begin
            right_nxt = in_byte;
          end
          seen_nxt = in_level;
        end else if (op == OP_TICK) begin
          s1_nxt.smp_valid = 1'b1;
          s1_nxt.src       = SRC_PAIR;
          s1_nxt.byte_l    = left_r;
          s1_nxt.byte_r    = right_r;
        end
      end
      default: begin
        s1_nxt.smp_valid = 1'b0;
      end
    endcase
    s1_nxt.full = full_nxt;
  end

  // Configuration registers and control state; a mode write clears the state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_DIRECT;
      vol_r    <= VOL_RESET;
      thr_r    <= THR_RESET;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      occ_r    <= '0;
      full_r   <= 1'b0;
      parity_r <= 1'b0;
      left_r   <= LATCH_MID;
      right_r  <= LATCH_MID;
      seen_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_MODE: begin
          mode_r   <= mode_t'(cfg_data[1:0]);
          rd_ptr_r <= '0;
          wr_ptr_r <= '0;
          occ_r    <= '0;
          full_r   <= 1'b0;
          parity_r <= 1'b0;
          left_r   <= LATCH_MID;
          right_r  <= LATCH_MID;
          seen_r   <= 1'b0;
        end
        REG_VOLUME:    vol_r <= cfg_data[3:0];
        REG_THRESHOLD: thr_r <= cfg_data;
        default: begin
          vol_r <= vol_r;
        end
      endcase
    end else if (accept) begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      occ_r    <= occ_nxt;
      full_r   <= full_nxt;
      parity_r <= parity_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      seen_r   <= seen_nxt;
    end
  end

  // Sample memory: a push writes, a pop reads; the read data waits in rdata_r.
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_ptr_r] <= in_byte;
    end
    if (accept && rd_en) begin
      rdata_r <= mem[rd_ptr_r];
    end
  end

  // First-stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  // Second stage: scale the bytes and keep the held sample of the FIFO mode.
  always_comb begin
    held_nxt = held_r;
    smp_l    = '0;
    smp_r    = '0;
    case (s1_r.src)
      SRC_PAIR: begin
        smp_l = to_sample(s1_r.byte_l, vol_r);
        smp_r = to_sample(s1_r.byte_r, vol_r);
      end
      SRC_POP: begin
        held_nxt = to_sample(rdata_r, vol_r);
        smp_l    = held_nxt;
        smp_r    = held_nxt;
      end
      SRC_ZERO: begin
        held_nxt = '0;
      end
      SRC_HOLD: begin
        smp_l = held_r;
        smp_r = held_r;
      end
      default: begin
        held_nxt = held_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cfg_wr && cfg_index == REG_MODE) begin
      held_r <= '0;
    end else if (s1_valid_r && advance) begin
      held_r <= held_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_data_r <= {6'd0, s1_r.ovf, s1_r.full, smp_r, smp_l};
      out_user_r <= s1_r.smp_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Checks on the FIFO bookkeeping and the pipeline.
  `PPAD_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, occ_r <= OCC_W'(FIFO_DEPTH),
    "occupancy above FIFO depth")
  `PPAD_ASSERT_NOW(a_stall_full, clk, rst_n, !in_tready, s1_valid_r && out_valid_r,
    "input stalled with a free stage")
  `PPAD_ASSERT_NEXT(a_push_count, clk, rst_n, accept && wr_en && !cfg_wr,
    occ_r == $past(occ_r) + OCC_W'(1), "accepted push did not raise occupancy")
  `PPAD_ASSERT_NOW(a_ovf_mode, clk, rst_n, out_valid_r && out_data_r[33],
    mode_r == MODE_FIFO && !out_user_r, "overflow flagged outside a FIFO push")

endmodule

`default_nettype wire
